// ----- rtl/ugpb_pkg.sv -----
// ugpb_pkg.sv: constants, op codes and the queued command type of the grid binning block
// no dependencies; compiled first
package ugpb_pkg;

    // grid geometry and capacities
    localparam int GRID_W      = 64;
    localparam int GRID_H      = 64;
    localparam int CELL_SIZE   = 16;
    localparam int CELL_SLOTS  = 8;
    localparam int MAX_PARTS   = 4096;
    localparam int LIMIT_RESET = 8;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 24;
    localparam int COL_W   = 6;
    localparam int ROW_W   = 6;
    localparam int SLOT_W  = 3;
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 4;
    localparam int LIMIT_W = 4;

    // derived sizes
    localparam int NCELLS    = GRID_W * GRID_H;
    localparam int CELL_AW   = $clog2(NCELLS);
    localparam int ENT_DEPTH = NCELLS * CELL_SLOTS;
    localparam int ENT_AW    = $clog2(ENT_DEPTH);
    localparam int NUM_W     = $clog2(MAX_PARTS + 1);
    localparam int BIN_SHIFT = $clog2(CELL_SIZE * 256);

    // count memory word: epoch mark over the count
    localparam int EPOCH_W = 4;
    localparam int CWORD_W = EPOCH_W + CNT_W;

    // command queue between front and back
    localparam int FIFO_DEPTH = 4;

    // input function codes
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // classified item handed from front to back
    typedef struct packed {
        op_t                op;
        logic [CELL_AW-1:0] cell_idx;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [SLOT_W-1:0]  slot;
        logic [IDX_W-1:0]   pidx;
        logic               has_num;
        logic               in_grid;
    } cmd_t;

endpackage

// ----- rtl/ugpb_if.sv -----
// ugpb_if.sv: request and response channel interfaces, valid/ready with field payload
// depends on ugpb_pkg
interface ugpb_req_if;
    import ugpb_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [COL_W-1:0]         cell_col;
    logic [ROW_W-1:0]         cell_row;
    logic [SLOT_W-1:0]        slot_sel;

    modport source (
        output valid, func, pos_x, pos_y, cell_col, cell_row, slot_sel,
        input  ready
    );
    modport sink (
        input  valid, func, pos_x, pos_y, cell_col, cell_row, slot_sel,
        output ready
    );
endinterface

interface ugpb_rsp_if;
    import ugpb_pkg::*;

    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;
    logic [SLOT_W-1:0] out_slot;
    logic              stored;
    logic [IDX_W-1:0]  particle_index;
    logic [CNT_W-1:0]  entry_count;

    modport source (
        output valid, out_col, out_row, out_slot, stored, particle_index, entry_count,
        input  ready
    );
    modport sink (
        input  valid, out_col, out_row, out_slot, stored, particle_index, entry_count,
        output ready
    );
endinterface

// ----- rtl/ugpb_ram.sv -----
// ugpb_ram.sv: generic simple dual-port ram, one write port, one registered read port
// read during write at the same address returns the old word; defaults from ugpb_pkg
module ugpb_ram #(
    parameter int WIDTH = ugpb_pkg::CWORD_W,
    parameter int DEPTH = ugpb_pkg::NCELLS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ugpb_front.sv -----
// ugpb_front.sv: accepts requests, bins positions into cells and numbers particles
// depends on ugpb_pkg and ugpb_if; feeds the command queue
module ugpb_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            hold_off,
    ugpb_req_if.sink        req,
    output logic            push_valid,
    input  logic            push_ready,
    output ugpb_pkg::cmd_t  push_cmd
);
    import ugpb_pkg::*;

    localparam int QW = POS_W - 1 - BIN_SHIFT;

    logic             hold_valid_reg;
    cmd_t             cmd_reg;
    logic [NUM_W-1:0] next_number_reg;
    logic [NUM_W-1:0] next_number_next;
    cmd_t             cmd;
    logic             exhausted;
    logic             accept;

    // divide by cell size, truncate, clamp into the grid
    function automatic logic [COL_W-1:0] bin_coord(input logic [POS_W-1:0] pos,
                                                   input int span);
        logic [QW-1:0]    q;
        logic [COL_W-1:0] r;
        q = pos[POS_W-2:BIN_SHIFT];
        if (pos[POS_W-1])
            r = '0;
        else if (int'(q) >= span)
            r = COL_W'(span - 1);
        else
            r = COL_W'(q);
        return r;
    endfunction

    function automatic logic [CELL_AW-1:0] cell_of(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        return CELL_AW'(int'(row) * GRID_W + int'(col));
    endfunction

    // classify the incoming item
    always_comb
    begin
        cmd              = '0;
        cmd.op           = OP_NONE;
        next_number_next = next_number_reg;
        exhausted        = (next_number_reg >= NUM_W'(MAX_PARTS));
        case (req.func)
            FUNC_CLEAR:
            begin
                cmd.op           = OP_CLEAR;
                next_number_next = '0;
            end
            FUNC_INSERT:
            begin
                cmd.op       = OP_INSERT;
                cmd.col      = bin_coord(req.pos_x, GRID_W);
                cmd.row      = ROW_W'(bin_coord(req.pos_y, GRID_H));
                cmd.cell_idx = cell_of(cmd.row, cmd.col);
                cmd.in_grid  = 1'b1;
                if (!exhausted)
                begin
                    cmd.has_num      = 1'b1;
                    cmd.pidx         = next_number_reg[IDX_W-1:0];
                    next_number_next = next_number_reg + NUM_W'(1);
                end
            end
            FUNC_READ:
            begin
                cmd.op       = OP_READ;
                cmd.col      = req.cell_col;
                cmd.row      = req.cell_row;
                cmd.slot     = req.slot_sel;
                cmd.cell_idx = cell_of(req.cell_row, req.cell_col);
                cmd.in_grid  = (int'(req.cell_col) < GRID_W) && (int'(req.cell_row) < GRID_H);
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    // one holding register toward the queue
    assign req.ready  = !hold_off && (!hold_valid_reg || push_ready);
    assign accept     = req.valid && req.ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg  <= 1'b0;
            next_number_reg <= '0;
        end
        else if (accept)
        begin
            hold_valid_reg  <= 1'b1;
            next_number_reg <= next_number_next;
        end
        else if (push_ready)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

`ifndef SYNTH
    // numbering saturates at capacity
    a_number_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_number_reg <= NUM_W'(MAX_PARTS))
        else $error("particle numbering ran past capacity");
`endif

endmodule

// ----- rtl/ugpb_fifo.sv -----
// ugpb_fifo.sv: short command queue between the front and back parts
// depends on ugpb_pkg; DEPTH from 2 to 16
module ugpb_fifo #(
    parameter int DEPTH = ugpb_pkg::FIFO_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  ugpb_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ugpb_pkg::cmd_t pop_cmd
);
    import ugpb_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    cmd_t              slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              push;
    logic              pop;

    assign push_ready = (fill_reg != FILL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = slots_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/ugpb_back.sv -----
// ugpb_back.sv: carries out queued commands on the count and entry memories
// depends on ugpb_pkg, ugpb_if and ugpb_ram; drives the response channel
module ugpb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  ugpb_pkg::cmd_t     pop_cmd,
    input  logic [ugpb_pkg::CNT_W-1:0] limit,
    output logic               sweeping,
    ugpb_rsp_if.source         rsp
);
    import ugpb_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [SLOT_W-1:0] slot;
        logic              stored;
        logic [IDX_W-1:0]  pidx;
        logic [CNT_W-1:0]  cnt;
    } res_t;

    // execute stage
    logic               b_valid_reg;
    cmd_t               b_cmd_reg;
    // epoch mark and clearing sweep
    logic [EPOCH_W-1:0] epoch_reg;
    logic               sweep_reg;
    logic [CELL_AW-1:0] sweep_addr_reg;
    // last-write forwarding
    logic               fwd_cnt_valid_reg;
    logic [CELL_AW-1:0] fwd_cnt_addr_reg;
    logic [CNT_W-1:0]   fwd_cnt_data_reg;
    logic               fwd_ent_valid_reg;
    logic [ENT_AW-1:0]  fwd_ent_addr_reg;
    logic [IDX_W-1:0]   fwd_ent_data_reg;
    // output register
    logic               out_valid_reg;
    res_t               out_reg;

    logic               move;
    logic               pop;
    logic               do_step;
    logic               b_is_clear;
    logic [CWORD_W-1:0] cword_rd;
    logic [IDX_W-1:0]   ent_rd;
    logic [CNT_W-1:0]   cur_count;
    logic [CNT_W-1:0]   new_count;
    logic [IDX_W-1:0]   cur_entry;
    logic [ENT_AW-1:0]  b_ent_raddr;
    logic [ENT_AW-1:0]  b_ent_waddr;
    logic               ins_wr;
    res_t               res;
    logic               cnt_we;
    logic [CELL_AW-1:0] cnt_waddr;
    logic [CWORD_W-1:0] cnt_wdata;
    logic               ent_we;

    function automatic logic [ENT_AW-1:0] ent_addr(input logic [CELL_AW-1:0] cidx,
                                                   input logic [SLOT_W-1:0] slot);
        return ENT_AW'(int'(cidx) * CELL_SLOTS + int'(slot));
    endfunction

    // stage advance and queue pop
    assign move       = !out_valid_reg || rsp.ready;
    assign b_is_clear = b_valid_reg && (b_cmd_reg.op == OP_CLEAR);
    assign pop_ready  = move && !sweep_reg && !b_is_clear;
    assign pop        = pop_valid && pop_ready;
    assign do_step    = move && b_valid_reg;
    assign sweeping   = sweep_reg;

    // count memory: epoch mark over count per cell
    ugpb_ram #(
        .WIDTH (CWORD_W),
        .DEPTH (NCELLS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (pop),
        .raddr (pop_cmd.cell_idx),
        .rdata (cword_rd)
    );

    // entry memory: particle numbers per cell slot
    ugpb_ram #(
        .WIDTH (IDX_W),
        .DEPTH (ENT_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (b_ent_waddr),
        .wdata (b_cmd_reg.pidx),
        .re    (pop),
        .raddr (ent_addr(pop_cmd.cell_idx, pop_cmd.slot)),
        .rdata (ent_rd)
    );

    // current count and entry with last-write forwarding
    always_comb
    begin
        b_ent_raddr = ent_addr(b_cmd_reg.cell_idx, b_cmd_reg.slot);
        if (fwd_cnt_valid_reg && (fwd_cnt_addr_reg == b_cmd_reg.cell_idx))
            cur_count = fwd_cnt_data_reg;
        else if (cword_rd[CWORD_W-1:CNT_W] == epoch_reg)
            cur_count = cword_rd[CNT_W-1:0];
        else
            cur_count = '0;
        if (fwd_ent_valid_reg && (fwd_ent_addr_reg == b_ent_raddr))
            cur_entry = fwd_ent_data_reg;
        else
            cur_entry = ent_rd;
        b_ent_waddr = ent_addr(b_cmd_reg.cell_idx, cur_count[SLOT_W-1:0]);
    end

    // carry out the command
    always_comb
    begin
        res       = '0;
        ins_wr    = 1'b0;
        new_count = cur_count;
        case (b_cmd_reg.op)
            OP_INSERT:
            begin
                res.col = b_cmd_reg.col;
                res.row = b_cmd_reg.row;
                if (b_cmd_reg.has_num)
                begin
                    res.pidx = b_cmd_reg.pidx;
                    if (cur_count < limit)
                    begin
                        res.stored = 1'b1;
                        res.slot   = cur_count[SLOT_W-1:0];
                        new_count  = cur_count + CNT_W'(1);
                        ins_wr     = 1'b1;
                    end
                end
                res.cnt = new_count;
            end
            OP_READ:
            begin
                res.col  = b_cmd_reg.col;
                res.row  = b_cmd_reg.row;
                res.slot = b_cmd_reg.slot;
                if (b_cmd_reg.in_grid)
                begin
                    res.cnt = cur_count;
                    if ((CNT_W'(b_cmd_reg.slot) < cur_count) &&
                        (int'(b_cmd_reg.slot) < CELL_SLOTS))
                    begin
                        res.stored = 1'b1;
                        res.pidx   = cur_entry;
                    end
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    // memory write ports, sweep takes the count port
    always_comb
    begin
        ent_we = do_step && ins_wr;
        if (sweep_reg)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = sweep_addr_reg;
            cnt_wdata = {epoch_reg, CNT_W'(0)};
        end
        else
        begin
            cnt_we    = do_step && ins_wr;
            cnt_waddr = b_cmd_reg.cell_idx;
            cnt_wdata = {epoch_reg, new_count};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            epoch_reg         <= '0;
            sweep_reg         <= 1'b1;
            sweep_addr_reg    <= '0;
            fwd_cnt_valid_reg <= 1'b0;
            fwd_ent_valid_reg <= 1'b0;
        end
        else
        begin
            if (move)
            begin
                b_valid_reg       <= pop;
                out_valid_reg     <= b_valid_reg;
                fwd_cnt_valid_reg <= do_step && ins_wr;
                fwd_ent_valid_reg <= do_step && ins_wr;
            end
            if (sweep_reg)
            begin
                sweep_addr_reg <= sweep_addr_reg + CELL_AW'(1);
                if (sweep_addr_reg == CELL_AW'(NCELLS - 1))
                begin
                    sweep_reg <= 1'b0;
                end
            end
            else if (do_step && b_is_clear)
            begin
                epoch_reg <= epoch_reg + EPOCH_W'(1);
                if (epoch_reg == {EPOCH_W{1'b1}})
                begin
                    sweep_reg      <= 1'b1;
                    sweep_addr_reg <= '0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_cmd_reg <= pop_cmd;
        end
        if (do_step)
        begin
            out_reg <= res;
        end
        if (do_step && ins_wr)
        begin
            fwd_cnt_addr_reg <= b_cmd_reg.cell_idx;
            fwd_cnt_data_reg <= new_count;
            fwd_ent_addr_reg <= b_ent_waddr;
            fwd_ent_data_reg <= b_cmd_reg.pidx;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.out_col        = out_reg.col;
    assign rsp.out_row        = out_reg.row;
    assign rsp.out_slot       = out_reg.slot;
    assign rsp.stored         = out_reg.stored;
    assign rsp.particle_index = out_reg.pidx;
    assign rsp.entry_count    = out_reg.cnt;

`ifndef SYNTH
    // no command sits in the execute stage while the count memory is swept
    a_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg |-> !b_valid_reg)
        else $error("command in flight during count sweep");

    // a sweep only starts once the epoch has wrapped
    a_sweep_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sweep_reg) |-> (epoch_reg == '0))
        else $error("count sweep started without epoch wrap");

    // reported count stays within cell capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.entry_count <= CNT_W'(CELL_SLOTS)))
        else $error("cell count above capacity");

    // a valid slot always lies below the cell count
    a_slot_below: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.stored) |-> (CNT_W'(rsp.out_slot) < rsp.entry_count))
        else $error("stored slot not below cell count");
`endif

endmodule

// ----- rtl/uniform_grid_particle_binning.sv -----
// channel  side  transfer       payload
// req      in    valid & ready  func, pos_x, pos_y, cell_col, cell_row, slot_sel
// rsp      out   valid & ready  out_col, out_row, out_slot, stored, particle_index, entry_count
// cfg      in    cfg_we         cfg_wdata (cell_limit)
//
// inserts and reads sustain one transfer per cycle when no clear, sweep or stalled rsp holds
// them; results pass the front register, command queue and execute stage with output register
// each cell count is a read-modify-write on the count ram; the last write is forwarded
// a clear blocks the queue while it executes; every sixteenth clear wraps the epoch mark
// and starts a sweep of all 4096 count ram words, as does reset, with req.ready low meanwhile
// a stalled rsp holds the execute stage; the queue lets the front keep taking items until full
//
// top level of the grid binning block; depends on ugpb_pkg, ugpb_if, ugpb_front,
// ugpb_fifo, ugpb_back and ugpb_ram
module uniform_grid_particle_binning #(
    parameter int FIFO_DEPTH = ugpb_pkg::FIFO_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ugpb_pkg::LIMIT_W-1:0] cfg_wdata,
    ugpb_req_if.sink                     req,
    ugpb_rsp_if.source                   rsp
);
    import ugpb_pkg::*;

    logic [LIMIT_W-1:0] cell_limit_reg;
    logic [CNT_W-1:0]   limit;
    logic               push_valid;
    logic               push_ready;
    cmd_t               push_cmd;
    logic               pop_valid;
    logic               pop_ready;
    cmd_t               pop_cmd;
    logic               sweeping;

    // cell limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_limit_reg <= LIMIT_W'(LIMIT_RESET);
        end
        else if (cfg_we)
        begin
            cell_limit_reg <= cfg_wdata;
        end
    end

    // limit saturates at the slot count
    assign limit = (int'(cell_limit_reg) > CELL_SLOTS) ? CNT_W'(CELL_SLOTS)
                                                        : CNT_W'(cell_limit_reg);

    ugpb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_off   (sweeping),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    ugpb_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    ugpb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .limit     (limit),
        .sweeping  (sweeping),
        .rsp       (rsp)
    );

endmodule
